// File: hw/rtl/tpif_pkg.sv
// ----------------------------------------------------------------------------
// tpif_pkg: shared types and constants for the threshold packer
// Item layouts on both channels, configuration register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tpif_pkg;

    typedef struct packed {
        logic [7:0] gray_pixel;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [14:0] vram_address;
        logic [7:0]  vram_byte;
        logic        frame_end;
    } t_out_item;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd720;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd350;

    localparam logic [7:0] LEFT_PIXEL_BIT = 8'h80;

endpackage

// File: hw/rtl/tpif_pack.sv
// ----------------------------------------------------------------------------
// tpif_pack: pixel thresholding, bit packing and bank address generation
// Holds the frame position and the partial byte, and for each item that
// advances it forms the framebuffer write, if any.
// ----------------------------------------------------------------------------
module tpif_pack #(
    parameter int FB_BYTES   = 32768,
    parameter int BANK_BYTES = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  tpif_pkg::t_in_item         i_item,
    input  logic [tpif_pkg::CFG_W-1:0] i_width,
    input  logic [tpif_pkg::CFG_W-1:0] i_height,
    output logic                       o_emit,
    output tpif_pkg::t_out_item        o_result
);
    import tpif_pkg::*;

    localparam int SPAN   = 3 * BANK_BYTES + 255 * 128 + 128;
    localparam int ADDR_W = $clog2(((SPAN > FB_BYTES) ? SPAN : FB_BYTES) + 1);
    localparam logic [ADDR_W-1:0] FB_LIMIT = ADDR_W'(FB_BYTES);
    localparam logic [ADDR_W-1:0] BANK_SZ  = ADDR_W'(BANK_BYTES);

    logic [CFG_W-1:0] r_col, n_col;
    logic [CFG_W-1:0] r_row, n_row;
    logic [7:0]       r_acc, n_acc;
    logic             r_stopped, n_stopped;

    logic [CFG_W-1:0]  w_col, w_row;
    logic [7:0]        w_acc, w_acc_or;
    logic              w_stopped, w_stop_now, w_skip;
    logic [7:0]        w_pitch;
    logic [ADDR_W-1:0] w_base, w_addr;
    logic [CFG_W:0]    w_col_inc, w_row_inc;
    logic              w_row_end, w_byte_done, w_last;

    always_comb begin
        w_col     = i_item.frame_start ? '0 : r_col;
        w_row     = i_item.frame_start ? '0 : r_row;
        w_acc     = i_item.frame_start ? '0 : r_acc;
        w_stopped = i_item.frame_start ? 1'b0 : r_stopped;

        w_skip      = (i_width == '0) || (w_row >= i_height);
        w_pitch     = 8'(({1'b0, i_width} + 11'd7) >> 3);
        w_base      = ADDR_W'(w_row[1:0]) * BANK_SZ + ADDR_W'(w_row[9:2]) * ADDR_W'(w_pitch);
        w_stop_now  = w_stopped || (w_base >= FB_LIMIT);
        w_acc_or    = w_acc | (i_item.gray_pixel[7] ? (LEFT_PIXEL_BIT >> w_col[2:0]) : 8'h00);
        w_col_inc   = {1'b0, w_col} + 11'd1;
        w_row_inc   = {1'b0, w_row} + 11'd1;
        w_row_end   = w_col_inc >= {1'b0, i_width};
        w_byte_done = (w_col[2:0] == 3'd7) || w_row_end;
        w_last      = w_row_end && (w_row_inc >= {1'b0, i_height});
        w_addr      = w_base + ADDR_W'(w_col[9:3]);

        o_emit                = !w_skip && w_byte_done && !w_stop_now && (w_addr < FB_LIMIT);
        o_result.vram_address = w_addr[14:0];
        o_result.vram_byte    = w_acc_or;
        o_result.frame_end    = w_last;

        if (w_skip) begin
            n_col     = w_col;
            n_row     = w_row;
            n_acc     = w_acc;
            n_stopped = w_stopped;
        end else begin
            n_col     = w_row_end ? '0 : w_col_inc[CFG_W-1:0];
            n_row     = w_row_end ? w_row_inc[CFG_W-1:0] : w_row;
            n_acc     = w_byte_done ? 8'h00 : w_acc_or;
            n_stopped = w_stop_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_acc     <= '0;
            r_stopped <= 1'b0;
        end else if (i_advance) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_acc     <= n_acc;
            r_stopped <= n_stopped;
        end
    end

endmodule

// File: hw/rtl/threshold_pack_interleaved_fb.sv
// ----------------------------------------------------------------------------
// threshold_pack_interleaved_fb: 1bpp packer for a four-bank framebuffer
//
//   channel  direction  handshake                  payload
//   in       in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out      out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg      in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One item is accepted per cycle; an item goes from the input register
// through the packing logic, whose write, if any, enters the output register.
// The rate is one item per cycle, limited only by output stalls.
// Reset is synchronous and restores the width and height registers.
// A stalled output holds its item and stalls the input once the input
// register is also full.
// ----------------------------------------------------------------------------
module threshold_pack_interleaved_fb #(
    parameter int FB_BYTES   = 32768,
    parameter int BANK_BYTES = 8192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tpif_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tpif_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [tpif_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpif_pkg::CFG_W-1:0]     i_cfg_data
);
    import tpif_pkg::*;

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    logic      w_out_free;
    logic      w_advance;
    logic      w_emit;
    t_out_item w_result;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tpif_pack #(
        .FB_BYTES   (FB_BYTES),
        .BANK_BYTES (BANK_BYTES)
    ) u_pack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_item <= w_result;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a held item");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input item lost");

    a_result_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_free && !w_advance) |=> !r_out_valid)
        else $error("result appeared without an item advancing");

endmodule

// File: tb/tb_threshold_pack_interleaved_fb.sv
// ----------------------------------------------------------------------------
// tb_threshold_pack_interleaved_fb: self-checking bench for the 1bpp packer
// A short table of directed items comes first. Random frames follow under
// three idle patterns, then one frame that steps rows at width one and is
// widened near the end of the last bank, where writes run past the buffer
// and the frame stops. Every write the block makes is compared with the next
// expected one, taken from the table or from a packer kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_threshold_pack_interleaved_fb;
    import tpif_pkg::*;

    localparam int FB_BYTES    = 32768;
    localparam int BANK_BYTES  = 8192;
    localparam int TAIL_CYCLES = 6;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DIR_STEPS   = 30;

    typedef enum logic [1:0] {STEP_CFG, STEP_PIXEL, STEP_PIXEL_KNOWN} t_step_kind;

    typedef struct {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        t_in_item               px;
        t_out_item              known;
    } t_dir_step;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]      cfg_data  = '0;

    logic [CFG_W-1:0]      pk_width   = WIDTH_RESET;
    logic [CFG_W-1:0]      pk_height  = HEIGHT_RESET;
    logic [9:0]            pk_col     = '0;
    logic [9:0]            pk_row     = '0;
    logic [7:0]            pk_acc     = '0;
    logic                  pk_stopped = 1'b0;

    t_out_item             pending_writes[$];
    int                    n_fail      = 0;
    int                    idle_cycles = 0;
    int                    gap_pct     = 0;
    int                    stall_pct   = 0;

    t_dir_step dir_table [DIR_STEPS] = '{
        '{STEP_CFG,         CFG_IMAGE_WIDTH,  10'd9,    9'd0,           24'd0},
        '{STEP_CFG,         CFG_IMAGE_HEIGHT, 10'd2,    9'd0,           24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b1}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd128, 1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd127, 1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd0,   1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd0,   1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd0,   1'b0}, 24'd0},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd128, 1'b0},
          {15'd0, 8'hC9, 1'b0}},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd200, 1'b0},
          {15'd1, 8'h80, 1'b0}},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b0}, 24'd0},
        '{STEP_CFG,         CFG_IMAGE_WIDTH,  10'd1,    9'd0,           24'd0},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd130, 1'b0},
          {15'd8192, 8'hC0, 1'b1}},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b0}, 24'd0},
        '{STEP_CFG,         CFG_IMAGE_HEIGHT, 10'd0,    9'd0,           24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b1}, 24'd0},
        '{STEP_CFG,         CFG_IMAGE_HEIGHT, 10'd3,    9'd0,           24'd0},
        '{STEP_CFG,         CFG_IMAGE_WIDTH,  10'd0,    9'd0,           24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b1}, 24'd0},
        '{STEP_CFG,         CFG_IMAGE_WIDTH,  10'd1,    9'd0,           24'd0},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd128, 1'b1},
          {15'd0, 8'h80, 1'b0}},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd127, 1'b0},
          {15'd8192, 8'h00, 1'b0}},
        '{STEP_PIXEL_KNOWN, CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b0},
          {15'd16384, 8'h80, 1'b1}},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd0,   1'b0}, 24'd0},
        '{STEP_CFG,         CFG_IMAGE_WIDTH,  10'd1023, 9'd0,           24'd0},
        '{STEP_CFG,         CFG_IMAGE_HEIGHT, 10'd1023, 9'd0,           24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd0,   1'b1}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b0}, 24'd0},
        '{STEP_PIXEL,       CFG_IMAGE_WIDTH,  10'd0,    {8'd255, 1'b1}, 24'd0}
    };

    threshold_pack_interleaved_fb #(
        .FB_BYTES   (FB_BYTES),
        .BANK_BYTES (BANK_BYTES)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit pack_pixel(input t_in_item px, output t_out_item wr);
        int unsigned pitch, base, addr, col, row;
        bit          row_end, got;
        wr  = '0;
        got = 1'b0;
        if (px.frame_start) begin
            pk_col     = '0;
            pk_row     = '0;
            pk_acc     = '0;
            pk_stopped = 1'b0;
        end
        if (pk_width == '0 || pk_row >= pk_height) begin
            return 1'b0;
        end
        col   = pk_col;
        row   = pk_row;
        pitch = (32'(pk_width) + 32'd7) >> 3;
        base  = (row % 4) * BANK_BYTES + (row / 4) * pitch;
        if (base >= FB_BYTES) begin
            pk_stopped = 1'b1;
        end
        if (px.gray_pixel >= 8'd128) begin
            pk_acc = pk_acc | (LEFT_PIXEL_BIT >> (col % 8));
        end
        row_end = (col + 1 >= pk_width);
        if (col % 8 == 7 || row_end) begin
            addr = base + col / 8;
            if (!pk_stopped && addr < FB_BYTES) begin
                wr.vram_address = 15'(addr);
                wr.vram_byte    = pk_acc;
                wr.frame_end    = row_end && (row + 1 >= pk_height);
                got             = 1'b1;
            end
            pk_acc = '0;
        end
        if (row_end) begin
            pk_col = '0;
            pk_row = 10'(row + 1);
        end else begin
            pk_col = 10'(col + 1);
        end
        return got;
    endfunction

    task automatic push_pixel(input t_in_item px, input bit known, input t_out_item lit);
        t_out_item wr;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (pack_pixel(px, wr) && !known) begin
            pending_writes.push_back(wr);
        end
        if (known) begin
            pending_writes.push_back(lit);
        end
    endtask

    task automatic push_run(input int count, input bit first_start);
        t_in_item px;
        for (int k = 0; k < count; k++) begin
            px.frame_start = first_start && (k == 0);
            px.gray_pixel  = 8'($urandom_range(255));
            push_pixel(px, 1'b0, '0);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  pk_width  = val;
            CFG_IMAGE_HEIGHT: pk_height = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic run_random(input int goal);
        int       counted, w, h, npix, extra, pick, cap;
        t_in_item px;
        counted = 0;
        while (counted < goal) begin
            w    = $urandom_range(1, 40);
            h    = $urandom_range(1, 5);
            pick = $urandom_range(0, 19);
            cap  = 0;
            if (pick == 0) begin
                w = 0;
            end else if (pick == 1) begin
                h = 0;
            end else if (pick == 2) begin
                w   = 1023;
                h   = 1;
                cap = 48;
            end else if (pick == 3) begin
                w   = 1;
                h   = 1023;
                cap = 48;
            end else if (pick < 8) begin
                w = $urandom_range(1, 9);
            end
            settle();
            write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
            repeat ($urandom_range(1, 3)) begin
                npix = (w * h == 0) ? 4 : w * h;
                if (cap != 0) begin
                    npix = $urandom_range(1, cap);
                end else if ($urandom_range(9) == 0) begin
                    npix = $urandom_range(1, npix);
                end
                extra = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
                for (int k = 0; k < npix + extra; k++) begin
                    px.frame_start = (k == 0);
                    if ($urandom_range(3) == 0) begin
                        case ($urandom_range(3))
                            0: px.gray_pixel = 8'd0;
                            1: px.gray_pixel = 8'd127;
                            2: px.gray_pixel = 8'd128;
                            default: px.gray_pixel = 8'd255;
                        endcase
                    end else begin
                        px.gray_pixel = 8'($urandom_range(255));
                    end
                    push_pixel(px, 1'b0, '0);
                end
                if (w != 0 && h != 0) begin
                    counted += npix;
                end
            end
        end
    endtask

    task automatic check_write(input t_out_item got);
        t_out_item want;
        if (pending_writes.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) begin
                $display("unexpected write: addr %0d byte %h end %b",
                         got.vram_address, got.vram_byte, got.frame_end);
            end
        end else begin
            want = pending_writes.pop_front();
            if (got.vram_address !== want.vram_address || got.vram_byte !== want.vram_byte ||
                got.frame_end !== want.frame_end) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("write mismatch: expected addr %0d byte %h end %b,",
                             want.vram_address, want.vram_byte, want.frame_end,
                             " got addr %0d byte %h end %b",
                             got.vram_address, got.vram_byte, got.frame_end);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            check_write(out_item);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("threshold_pack_interleaved_fb verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct   = (ph == 0) ? 20 : (ph == 1) ? 88 : 0;
            stall_pct = (ph == 0) ? 88 : (ph == 1) ? 20 : 0;
            if (ph == 0) begin
                for (int i = 0; i < DIR_STEPS; i++) begin
                    if (dir_table[i].kind == STEP_CFG) begin
                        settle();
                        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
                    end else begin
                        push_pixel(dir_table[i].px, dir_table[i].kind == STEP_PIXEL_KNOWN,
                                   dir_table[i].known);
                    end
                end
            end
            run_random(230);
        end

        // Rows are stepped one pixel at a time, then the width is raised so
        // that the last bank's row base lands just below the buffer size and
        // later writes of that row run past it. A later row base lies beyond
        // the buffer, which stops the frame, so its end marker is lost even
        // after the width is lowered again.
        settle();
        write_reg(CFG_IMAGE_WIDTH, 10'd1);
        write_reg(CFG_IMAGE_HEIGHT, 10'd1023);
        push_run(263, 1'b1);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 10'd1008);
        push_run(24, 1'b0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 10'd1);
        push_run(4, 1'b0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 10'd1008);
        write_reg(CFG_IMAGE_HEIGHT, 10'd268);
        push_run(1, 1'b0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 10'd1);
        push_run(2, 1'b0);
        push_run(1, 1'b1);

        settle();
        if (n_fail == 0) begin
            $display("threshold_pack_interleaved_fb verification clean");
        end else begin
            $display("threshold_pack_interleaved_fb verification failed");
        end
        $finish;
    end

endmodule
